### src/nnce_pkg.sv
// ----------------------------------------------------------------------------
// nnce_pkg: shared types, constants and the pitch ROM builder
// Holds the subtractor result type and the elaboration-time construction of
// the 128-entry equal-tempered pitch table (note 69 = A4 = 440 Hz).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nnce_pkg;

  // Widths fixed by the transaction fields
  localparam int FREQ_W   = 24;
  localparam int NOTE_W   = 7;
  localparam int CENTS_W  = 8;
  localparam int CLASS_W  = 2;
  localparam int WIN_W    = 7;

  // Tuning class codes
  typedef enum logic [CLASS_W-1:0] {
    CLASS_FLAT  = 2'd0,
    CLASS_TUNE  = 2'd1,
    CLASS_SHARP = 2'd2
  } tune_class_t;

  // Shared subtractor operand width: holds diff * 100 and step << 8
  localparam int SUB_W    = 32;

  // Pitch table geometry and build constants
  localparam int TABLE_DEPTH = 128;
  localparam int A4_NOTE     = 69;
  localparam int A4_HZ       = 440;
  localparam int WORK_FRAC   = 20;
  localparam logic [63:0] ENTRY_MAX = 64'hFF_FFFF;

  typedef logic [TABLE_DEPTH-1:0][FREQ_W-1:0] pitch_rom_t;

  // Result of the shared subtract / compare unit
  typedef struct packed {
    logic [SUB_W-1:0] diff;  // a - b, modulo 2^SUB_W
    logic             ge;    // a >= b, unsigned
  } nnce_sub_res_t;

  // 2^(1/12) in Q2.30: largest x with x^12 below 2.0, found by bisection
  function automatic logic [63:0] semitone_q30();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] p;
    lo = 64'd1 << 30;
    hi = (64'd1 << 30) + (64'd1 << 27);
    for (int it = 0; it < 40; it++) begin
      mid = (lo + hi) >> 1;
      p   = 64'd1 << 30;
      for (int k = 0; k < 12; k++) begin
        p = (p * mid) >> 30;
      end
      if (p >= (64'd1 << 31)) begin
        hi = mid;
      end else begin
        lo = mid;
      end
    end
    return lo;
  endfunction

  // Restoring long division, elaboration only (divisor stays below 2^62)
  function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [63:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem  = rem - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Round a Q.20 value to the table's fraction bits, saturate to 24 bits
  function automatic logic [FREQ_W-1:0] to_entry(logic [63:0] wide, int frac);
    logic [63:0] v;
    int          sh;
    sh = WORK_FRAC - frac;
    v  = (wide + (64'd1 << (sh - 1))) >> sh;
    return (v > ENTRY_MAX) ? FREQ_W'(ENTRY_MAX) : v[FREQ_W-1:0];
  endfunction

  // Step up and down from A4 by one half step per entry
  function automatic pitch_rom_t build_rom(int frac);
    pitch_rom_t  rom;
    logic [63:0] r;
    logic [63:0] v;
    r = semitone_q30();
    v = 64'(A4_HZ) << WORK_FRAC;
    rom[A4_NOTE] = to_entry(v, frac);
    for (int n = A4_NOTE + 1; n < TABLE_DEPTH; n++) begin
      v = (v * r + (64'd1 << 29)) >> 30;
      rom[n] = to_entry(v, frac);
    end
    v = 64'(A4_HZ) << WORK_FRAC;
    for (int n = A4_NOTE - 1; n >= 0; n--) begin
      v = div_u64((v << 30) + (r >> 1), r);
      rom[n] = to_entry(v, frac);
    end
    return rom;
  endfunction

endpackage

### src/nnce_sub.sv
// ----------------------------------------------------------------------------
// nnce_sub: shared subtract / compare unit
// One unsigned subtractor used by the sequencer for the table search
// compares, distance terms, half-step spacing and the serial divide.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nnce_sub
  import nnce_pkg::*;
(
  input  logic [SUB_W-1:0] op_a,
  input  logic [SUB_W-1:0] op_b,
  output nnce_sub_res_t    res
);

  logic [SUB_W:0] full;

  // Borrow out of the top bit means a < b
  assign full     = {1'b0, op_a} - {1'b0, op_b};
  assign res.diff = full[SUB_W-1:0];
  assign res.ge   = ~full[SUB_W];

endmodule

### src/nearest_note_and_cents_error.sv
// ----------------------------------------------------------------------------
// nearest_note_and_cents_error: equal-tempered note tuner
// Datapath: the table search of up to 7 probes and the 8-step serial divide
//   run on one shared subtractor.
// Transactions: one at a time; the next is taken once the result is in the
//   output register, which waits while an earlier result is not yet taken.
// Reset (rst_n, synchronous): sequencer idle, no result pending, window = 5.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nearest_note_and_cents_error
  import nnce_pkg::*;
#(
  parameter int NOTE_COUNT         = 128,
  parameter int FREQ_FRACTION_BITS = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration
  input  logic                      cfg_wr_en,
  input  logic [WIN_W-1:0]          cfg_wr_data,
  // input channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [FREQ_W-1:0]         in_freq_hz,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [NOTE_W-1:0]         out_note_index,
  output logic signed [CENTS_W-1:0] out_cents_error,
  output logic [CLASS_W-1:0]        out_tune_class
);

  localparam pitch_rom_t        PitchRom   = build_rom(FREQ_FRACTION_BITS);
  localparam logic [NOTE_W-1:0] TopIdx     = NOTE_W'(NOTE_COUNT - 1);
  localparam int                REM_W      = SUB_W - 1;
  localparam logic [REM_W-1:0]  CentsScale = REM_W'(100);
  localparam logic [7:0]        CentsSat   = 8'd100;
  localparam logic [WIN_W-1:0]  WinReset   = WIN_W'(5);

  typedef enum logic [3:0] {
    S_IDLE, S_LOW, S_HIGH, S_SRCH, S_DLO, S_DHI, S_PICK,
    S_PITCH, S_DIFF, S_STEPA, S_STEPB, S_CHK, S_DIV, S_FIN
  } state_t;

  state_t                     state_r;
  logic [WIN_W-1:0]           win_r;
  logic [FREQ_W-1:0]          f_r;
  logic [NOTE_W-1:0]          lo_r;
  logic [NOTE_W-1:0]          hi_r;
  logic [NOTE_W-1:0]          note_r;
  logic                       flat_r;
  logic [FREQ_W-1:0]          diff_r;
  logic [FREQ_W-1:0]          step_r;
  logic [FREQ_W-1:0]          pa_r;
  logic [REM_W-1:0]           rem_r;
  logic [7:0]                 q_r;
  logic [2:0]                 cnt_r;
  logic                       out_valid_r;
  logic [NOTE_W-1:0]          out_note_r;
  logic signed [CENTS_W-1:0]  out_cents_r;
  logic [CLASS_W-1:0]         out_class_r;

  logic [NOTE_W-1:0]          rd_addr;
  logic [FREQ_W-1:0]          rd_data;
  logic [NOTE_W-1:0]          mid;
  logic [NOTE_W-1:0]          span;
  logic [NOTE_W-1:0]          nb_lo;
  logic [NOTE_W-1:0]          nb_hi;
  logic [SUB_W-1:0]           sub_a;
  logic [SUB_W-1:0]           sub_b;
  nnce_sub_res_t              sub_res;
  logic [6:0]                 mag;

  // Search bookkeeping
  assign mid  = NOTE_W'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);
  assign span = hi_r - lo_r;

  // Half-step neighbors, clamped at both ends of the table
  always_comb begin
    if (flat_r) begin
      nb_hi = (note_r == '0) ? NOTE_W'(1) : note_r;
      nb_lo = nb_hi - NOTE_W'(1);
    end else begin
      nb_lo = (note_r == TopIdx) ? (TopIdx - NOTE_W'(1)) : note_r;
      nb_hi = nb_lo + NOTE_W'(1);
    end
  end

  // Single ROM read port
  always_comb begin
    unique case (state_r)
      S_HIGH:          rd_addr = TopIdx;
      S_SRCH:          rd_addr = mid;
      S_DLO:           rd_addr = lo_r;
      S_DHI:           rd_addr = hi_r;
      S_PITCH, S_DIFF: rd_addr = note_r;
      S_STEPA:         rd_addr = nb_lo;
      S_STEPB:         rd_addr = nb_hi;
      default:         rd_addr = '0;
    endcase
  end

  assign rd_data = PitchRom[rd_addr];

  // Operand select for the shared subtractor
  always_comb begin
    unique case (state_r)
      S_LOW, S_DHI, S_PITCH: begin
        sub_a = SUB_W'(rd_data);
        sub_b = SUB_W'(f_r);
      end
      S_HIGH, S_SRCH, S_DLO, S_DIFF: begin
        sub_a = SUB_W'(f_r);
        sub_b = SUB_W'(rd_data);
      end
      S_PICK: begin
        sub_a = SUB_W'(step_r);
        sub_b = SUB_W'(diff_r);
      end
      S_STEPB: begin
        sub_a = SUB_W'(rd_data);
        sub_b = SUB_W'(pa_r);
      end
      S_CHK: begin
        sub_a = SUB_W'(rem_r);
        sub_b = {step_r, 8'h00};
      end
      S_DIV: begin
        sub_a = SUB_W'(rem_r);
        sub_b = SUB_W'(step_r) << cnt_r;
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  nnce_sub u_sub (
    .op_a (sub_a),
    .op_b (sub_b),
    .res  (sub_res)
  );

  // Saturated magnitude for the final result
  assign mag = (q_r > CentsSat) ? CentsSat[6:0] : q_r[6:0];

  // Sequencer, window register and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      win_r       <= WinReset;
    end else begin
      if (cfg_wr_en) begin
        win_r <= cfg_wr_data;
      end
      // the final state reloads the output register itself
      if (out_valid_r && out_ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            f_r     <= in_freq_hz;
            state_r <= S_LOW;
          end
        end
        // at or below the lowest note
        S_LOW: begin
          if (sub_res.ge) begin
            note_r  <= '0;
            state_r <= S_PITCH;
          end else begin
            state_r <= S_HIGH;
          end
        end
        // at or above the top note
        S_HIGH: begin
          if (sub_res.ge) begin
            note_r  <= TopIdx;
            state_r <= S_PITCH;
          end else begin
            lo_r    <= '0;
            hi_r    <= TopIdx;
            state_r <= S_SRCH;
          end
        end
        // binary search: one probe per cycle
        S_SRCH: begin
          if (span > NOTE_W'(1)) begin
            if (sub_res.ge) begin
              lo_r <= mid;
            end else begin
              hi_r <= mid;
            end
          end else begin
            state_r <= S_DLO;
          end
        end
        S_DLO: begin
          diff_r  <= sub_res.diff[FREQ_W-1:0];
          state_r <= S_DHI;
        end
        S_DHI: begin
          step_r  <= sub_res.diff[FREQ_W-1:0];
          state_r <= S_PICK;
        end
        // ties go to the lower note
        S_PICK: begin
          note_r  <= sub_res.ge ? lo_r : hi_r;
          state_r <= S_PITCH;
        end
        S_PITCH: begin
          flat_r <= sub_res.ge;
          if (sub_res.ge) begin
            diff_r  <= sub_res.diff[FREQ_W-1:0];
            state_r <= S_STEPA;
          end else begin
            state_r <= S_DIFF;
          end
        end
        S_DIFF: begin
          diff_r  <= sub_res.diff[FREQ_W-1:0];
          state_r <= S_STEPA;
        end
        S_STEPA: begin
          pa_r    <= rd_data;
          rem_r   <= REM_W'(diff_r) * CentsScale;
          state_r <= S_STEPB;
        end
        S_STEPB: begin
          step_r  <= sub_res.diff[FREQ_W-1:0];
          state_r <= S_CHK;
        end
        // zero spacing or quotient of 256 and more saturates early
        S_CHK: begin
          if (step_r == '0) begin
            q_r     <= (diff_r == '0) ? 8'd0 : CentsSat;
            state_r <= S_FIN;
          end else if (sub_res.ge) begin
            q_r     <= CentsSat;
            state_r <= S_FIN;
          end else begin
            q_r     <= '0;
            cnt_r   <= 3'd7;
            state_r <= S_DIV;
          end
        end
        // restoring divide, one quotient bit per cycle
        S_DIV: begin
          if (sub_res.ge) begin
            rem_r      <= sub_res.diff[REM_W-1:0];
            q_r[cnt_r] <= 1'b1;
          end
          if (cnt_r == 3'd0) begin
            state_r <= S_FIN;
          end else begin
            cnt_r <= cnt_r - 3'd1;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_note_r  <= note_r;
            out_cents_r <= flat_r ? -CENTS_W'({1'b0, mag}) : CENTS_W'({1'b0, mag});
            if (mag > win_r) begin
              out_class_r <= flat_r ? CLASS_FLAT : CLASS_SHARP;
            end else begin
              out_class_r <= CLASS_TUNE;
            end
            state_r <= S_IDLE;
          end else begin
            out_valid_r <= out_valid_r;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_note_index  = out_note_r;
  assign out_cents_error = out_cents_r;
  assign out_tune_class  = out_class_r;

endmodule
